FILE: rtl/core/imhq_pkg.sv
package imhq_pkg;

	localparam int KEY_W      = 8;
	localparam int REQ_W      = 2;
	localparam int IN_PRIO_W  = 32;
	localparam int OUT_PRIO_W = 32;

	localparam logic [REQ_W-1:0] REQ_UPSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PDEC,
		ST_QGOT,
		ST_POPGOT,
		ST_UPCHK,
		ST_UPCMP,
		ST_DNCHK,
		ST_DNL,
		ST_DNR,
		ST_DNCMP,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/indexed_min_heap_queue_top.sv
// Indexed min-heap priority queue with insert-or-update, pop-minimum and query.
// One request is in flight at a time; the next is taken in the idle cycle after the result beat.
// A sift steps through a check and a compare state per level moved up, and through check, left-child,
// optional right-child and compare states per level moved down.
// After reset a clearing pass empties the key map with busy high; the receiver cannot stall.
module indexed_min_heap_queue_top #(
	parameter int NUM_KEYS  = 256,
	parameter int PRIO_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [imhq_pkg::REQ_W-1:0]          req_type,
	input  logic [imhq_pkg::KEY_W-1:0]          key,
	input  logic [imhq_pkg::IN_PRIO_W-1:0]      prio,
	output logic                                done,
	output logic                                top_valid,
	output logic [imhq_pkg::KEY_W-1:0]          top_key,
	output logic [imhq_pkg::OUT_PRIO_W-1:0]     top_prio,
	output logic [$clog2(NUM_KEYS+1)-1:0]       entry_count,
	output logic                                query_found,
	output logic [imhq_pkg::OUT_PRIO_W-1:0]     query_prio
);
	import imhq_pkg::*;

	// Slot numbers run 1..NUM_KEYS; slot s sits at level floor(log2 s).
	localparam int SW  = $clog2(NUM_KEYS + 1);
	localparam int NL  = SW;
	localparam int OW  = (NL > 1) ? NL - 1 : 1;
	localparam int LW  = (NL > 1) ? $clog2(NL) : 1;
	localparam int KIW = $clog2(NUM_KEYS);
	localparam int DW  = KEY_W + PRIO_BITS;

	function automatic logic [LW-1:0] msb_idx(input logic [SW-1:0] s);
		logic [LW-1:0] r;
		r = '0;
		for (int i = 0; i < SW; i++) begin
			if (s[i]) begin
				r = LW'(i);
			end
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic [SW-1:0]        count_q;
	logic [SW-1:0]        pos_q;
	logic [KIW-1:0]       clr_q;
	logic [REQ_W-1:0]     req_q;
	logic [KEY_W-1:0]     key_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic                 qf_q;
	logic [PRIO_BITS-1:0] qp_q;
	logic [DW-1:0]        e_q;
	logic [DW-1:0]        ch_q;
	logic                 csel_q;
	logic [DW-1:0]        top_q;
	logic [LW-1:0]        rdl_q;

	// Key map: slot of each key, zero when absent.
	logic [SW-1:0]  kp_mem [NUM_KEYS];
	logic [SW-1:0]  kp_rd_q;
	logic           kp_re, kp_we;
	logic [KIW-1:0] kp_raddr, kp_waddr;
	logic [SW-1:0]  kp_wdata;

	always_ff @(posedge clk) begin
		if (kp_we) begin
			kp_mem[kp_waddr] <= kp_wdata;
		end
		if (kp_re) begin
			kp_rd_q <= kp_mem[kp_raddr];
		end
	end

	// Heap levels.
	logic           hp_re, hp_we;
	logic [SW-1:0]  hp_rslot, hp_wslot;
	logic [DW-1:0]  hp_wdata;
	logic [LW-1:0]  rd_lvl, wr_lvl;
	logic [OW-1:0]  rd_off, wr_off;
	logic [DW-1:0]  cell_rd [NL];
	logic [DW-1:0]  hp_rd;

	assign rd_lvl = msb_idx(hp_rslot);
	assign wr_lvl = msb_idx(hp_wslot);
	assign rd_off = OW'(hp_rslot & ~(SW'(1) << rd_lvl));
	assign wr_off = OW'(hp_wslot & ~(SW'(1) << wr_lvl));

	for (genvar g = 0; g < NL; g++) begin : g_lvl
		imhq_cell #(
			.LVL(g),
			.OW (OW),
			.DW (DW)
		) u_cell (
			.clk    (clk),
			.rd_en  (hp_re && (rd_lvl == LW'(g))),
			.rd_off (rd_off),
			.wr_en  (hp_we && (wr_lvl == LW'(g))),
			.wr_off (wr_off),
			.wr_data(hp_wdata),
			.rd_data(cell_rd[g])
		);
	end

	assign hp_rd = cell_rd[rdl_q];

	logic [KEY_W-1:0]     rd_key, e_key, ch_key, top_key_q;
	logic [PRIO_BITS-1:0] rd_prio, e_prio, ch_prio;
	assign rd_key    = hp_rd[DW-1 -: KEY_W];
	assign rd_prio   = hp_rd[PRIO_BITS-1:0];
	assign e_key     = e_q[DW-1 -: KEY_W];
	assign e_prio    = e_q[PRIO_BITS-1:0];
	assign ch_key    = ch_q[DW-1 -: KEY_W];
	assign ch_prio   = ch_q[PRIO_BITS-1:0];
	assign top_key_q = top_q[DW-1 -: KEY_W];

	// Decision terms.
	logic          key_ok_in;
	logic          kp_hit;
	logic          can_add;
	logic [SW:0]   l_ex, r_ex;
	logic          has_l, has_r;
	logic          up_move, dn_move, pick_r;

	assign key_ok_in = 32'(key) < 32'(NUM_KEYS);
	assign kp_hit    = (kp_rd_q != '0) && (kp_rd_q <= count_q);
	assign can_add   = count_q < SW'(NUM_KEYS);
	assign l_ex      = {pos_q, 1'b0};
	assign r_ex      = l_ex + (SW+1)'(1);
	assign has_l     = l_ex <= (SW+1)'(count_q);
	assign has_r     = r_ex <= (SW+1)'(count_q);
	assign up_move   = e_prio < rd_prio;
	assign dn_move   = e_prio > ch_prio;
	assign pick_r    = !(ch_prio < rd_prio);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == KIW'(NUM_KEYS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_UPSERT: state_d = key_ok_in ? ST_PDEC : ST_DONE;
						REQ_QUERY:  state_d = key_ok_in ? ST_PDEC : ST_DONE;
						REQ_POP:    state_d = (count_q != '0) ? ST_POPGOT : ST_DONE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_PDEC: begin
				if (req_q == REQ_QUERY) begin
					state_d = kp_hit ? ST_QGOT : ST_DONE;
				end else if (kp_rd_q == '0) begin
					state_d = can_add ? ST_UPCHK : ST_DONE;
				end else begin
					state_d = kp_hit ? ST_UPCHK : ST_DONE;
				end
			end
			ST_QGOT:   state_d = ST_DONE;
			ST_POPGOT: state_d = (count_q == SW'(1)) ? ST_DONE : ST_DNCHK;
			ST_UPCHK:  state_d = (pos_q == SW'(1)) ? ST_DNCHK : ST_UPCMP;
			ST_UPCMP:  state_d = up_move ? ST_UPCHK : ST_DNCHK;
			ST_DNCHK:  state_d = has_l ? ST_DNL : ST_FIN;
			ST_DNL:    state_d = has_r ? ST_DNR : ST_DNCMP;
			ST_DNR:    state_d = ST_DNCMP;
			ST_DNCMP:  state_d = dn_move ? ST_DNCHK : ST_FIN;
			ST_FIN:    state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory controls. The moving entry is held in e_q and written once, at its
	// final slot; entries it passes are shifted into the hole it leaves.
	always_comb begin
		kp_re    = 1'b0;
		kp_raddr = KIW'(key);
		kp_we    = 1'b0;
		kp_waddr = KIW'(e_key);
		kp_wdata = pos_q;
		hp_re    = 1'b0;
		hp_rslot = count_q;
		hp_we    = 1'b0;
		hp_wslot = pos_q;
		hp_wdata = e_q;
		case (state_q)
			ST_CLEAR: begin
				kp_we    = 1'b1;
				kp_waddr = clr_q;
				kp_wdata = '0;
			end
			ST_IDLE: begin
				kp_re = start && key_ok_in &&
					((req_type == REQ_UPSERT) || (req_type == REQ_QUERY));
				hp_re = start && (req_type == REQ_POP) && (count_q != '0);
			end
			ST_PDEC: begin
				hp_re    = (req_q == REQ_QUERY) && kp_hit;
				hp_rslot = kp_rd_q;
			end
			ST_POPGOT: begin
				kp_we    = 1'b1;
				kp_waddr = KIW'(top_key_q);
				kp_wdata = '0;
			end
			ST_UPCHK: begin
				hp_re    = pos_q != SW'(1);
				hp_rslot = pos_q >> 1;
			end
			ST_UPCMP: begin
				kp_we    = up_move;
				kp_waddr = KIW'(rd_key);
				hp_we    = up_move;
				hp_wdata = hp_rd;
			end
			ST_DNCHK: begin
				hp_re    = has_l;
				hp_rslot = SW'(l_ex);
			end
			ST_DNL: begin
				hp_re    = has_r;
				hp_rslot = SW'(r_ex);
			end
			ST_DNCMP: begin
				kp_we    = dn_move;
				kp_waddr = KIW'(ch_key);
				hp_we    = dn_move;
				hp_wdata = ch_q;
			end
			ST_FIN: begin
				kp_we = 1'b1;
				hp_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			count_q <= '0;
			clr_q   <= '0;
			qf_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR:  clr_q <= clr_q + KIW'(1);
				ST_IDLE:   if (start) qf_q <= 1'b0;
				ST_PDEC: begin
					if ((req_q == REQ_UPSERT) && (kp_rd_q == '0) && can_add) begin
						count_q <= count_q + SW'(1);
					end
				end
				ST_QGOT:   qf_q <= 1'b1;
				ST_POPGOT: count_q <= count_q - SW'(1);
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (hp_re) begin
			rdl_q <= rd_lvl;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_q  <= req_type;
					key_q  <= key;
					prio_q <= PRIO_BITS'(prio);
					qp_q   <= '0;
				end
			end
			ST_PDEC: begin
				e_q <= {key_q, prio_q};
				if (kp_rd_q == '0) begin
					pos_q <= count_q + SW'(1);
				end else begin
					pos_q <= kp_rd_q;
				end
			end
			ST_QGOT:   qp_q <= rd_prio;
			ST_POPGOT: begin
				e_q   <= hp_rd;
				pos_q <= SW'(1);
			end
			ST_UPCMP: begin
				if (up_move) pos_q <= pos_q >> 1;
			end
			ST_DNL: begin
				ch_q   <= hp_rd;
				csel_q <= 1'b0;
			end
			ST_DNR: begin
				if (pick_r) begin
					ch_q   <= hp_rd;
					csel_q <= 1'b1;
				end
			end
			ST_DNCMP: begin
				if (dn_move) begin
					pos_q <= SW'(l_ex) + SW'(csel_q);
					if (pos_q == SW'(1)) top_q <= ch_q;
				end
			end
			ST_FIN: begin
				if (pos_q == SW'(1)) top_q <= e_q;
			end
			default: begin
			end
		endcase
	end

	// Result beat.
	assign busy        = state_q != ST_IDLE;
	assign done        = state_q == ST_DONE;
	assign top_valid   = count_q != '0;
	assign top_key     = top_valid ? top_key_q : '0;
	assign top_prio    = top_valid ? OUT_PRIO_W'(top_q[PRIO_BITS-1:0]) : '0;
	assign entry_count = count_q;
	assign query_found = qf_q;
	assign query_prio  = OUT_PRIO_W'(qp_q);

`ifndef ASSERT_OFF
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request accepted without going busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SW'(NUM_KEYS)) else $error("entry count beyond capacity");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> (count_q == $past(count_q))) else $error("count changed while idle");
`endif

endmodule

FILE: rtl/core/imhq_cell.sv
module imhq_cell #(
	parameter int LVL = 0,
	parameter int OW  = 1,
	parameter int DW  = 40
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [OW-1:0] rd_off,
	input  logic          wr_en,
	input  logic [OW-1:0] wr_off,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data
);
	// One heap level: slots 2**LVL .. 2**(LVL+1)-1, addressed by offset in the level.
	localparam int AW    = (LVL > 0) ? LVL : 1;
	localparam int DEPTH = 2 ** LVL;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_off[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_off[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: tb/heap_checker.sv
module heap_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  key,
	input  logic [31:0] prio,
	input  logic        done,
	input  logic        top_valid,
	input  logic [7:0]  top_key,
	input  logic [31:0] top_prio,
	input  logic [8:0]  entry_count,
	input  logic        query_found,
	input  logic [31:0] query_prio,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import imhq_pkg::*;

	typedef struct packed {
		logic        tv;
		logic [7:0]  tk;
		logic [31:0] tp;
		logic [8:0]  cnt;
		logic        qf;
		logic [31:0] qp;
	} status_t;

	logic [7:0]  slot_key [1:256];
	logic [31:0] slot_prio [1:256];
	int          slot_of [0:255];
	int          n_held;
	status_t     status_fifo[$];

	function automatic void swap_slots(int a, int b);
		logic [7:0]  tk;
		logic [31:0] tp;
		tk = slot_key[a]; tp = slot_prio[a];
		slot_key[a] = slot_key[b]; slot_prio[a] = slot_prio[b];
		slot_key[b] = tk; slot_prio[b] = tp;
		slot_of[slot_key[a]] = a;
		slot_of[slot_key[b]] = b;
	endfunction

	function automatic void rise(int p);
		while (p > 1 && slot_prio[p] < slot_prio[p/2]) begin
			swap_slots(p, p/2);
			p = p / 2;
		end
	endfunction

	function automatic void sink(int p);
		int c;
		forever begin
			if (2*p > n_held) break;
			if (2*p+1 > n_held) c = 2*p;
			else c = (slot_prio[2*p] < slot_prio[2*p+1]) ? 2*p : 2*p+1;
			if (slot_prio[p] > slot_prio[c]) begin
				swap_slots(p, c);
				p = c;
			end else break;
		end
	endfunction

	function automatic status_t apply_request(logic [1:0] rq, logic [7:0] k, logic [31:0] pr);
		status_t s;
		int p;
		s = '0;
		if (rq == REQ_UPSERT) begin
			p = slot_of[k];
			if (p == 0) begin
				if (n_held < 256) begin
					n_held++;
					slot_key[n_held] = k; slot_prio[n_held] = pr;
					slot_of[k] = n_held;
					rise(n_held);
				end
			end else begin
				slot_prio[p] = pr;
				rise(p);
				sink(slot_of[k]);
			end
		end else if (rq == REQ_POP) begin
			if (n_held > 0) begin
				slot_of[slot_key[1]] = 0;
				if (n_held > 1) begin
					slot_key[1] = slot_key[n_held]; slot_prio[1] = slot_prio[n_held];
					slot_of[slot_key[1]] = 1;
				end
				n_held--;
				if (n_held > 0) sink(1);
			end
		end else if (rq == REQ_QUERY) begin
			p = slot_of[k];
			if (p != 0) begin
				s.qf = 1'b1;
				s.qp = slot_prio[p];
			end
		end
		s.tv  = n_held > 0;
		s.tk  = n_held > 0 ? slot_key[1] : '0;
		s.tp  = n_held > 0 ? slot_prio[1] : '0;
		s.cnt = n_held[8:0];
		return s;
	endfunction

	initial begin
		fail_count = 0;
		n_held = 0;
		foreach (slot_of[i]) slot_of[i] = 0;
	end

	assign pending = status_fifo.size();

	always @(posedge clk) begin
		status_t got, want;
		if (arst_n) begin
			// The result of a request can never come in its own accept cycle,
			// so checking before predicting keeps the order right.
			if (done) begin
				got = '{top_valid, top_key, top_prio, entry_count, query_found, query_prio};
				if (status_fifo.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("Unexpected result beat %p", got);
				end else begin
					want = status_fifo.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (start && !busy)
				status_fifo = {status_fifo, apply_request(req_type, key, prio)};
		end
	end
endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import imhq_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  req_type = REQ_QUERY;
	logic [7:0]  key = '0;
	logic [31:0] prio = '0;
	logic        busy, done, top_valid, query_found;
	logic [7:0]  top_key;
	logic [31:0] top_prio, query_prio;
	logic [8:0]  entry_count;
	int          fail_count, pending;
	int          idle_cycles = 0;
	int          n_sent = 0;
	int          n_fill = 0;

	// Sized for the clearing pass plus the slowest sift with margin.
	localparam int WATCHDOG_LIMIT = 5000;

	always #2 clk = ~clk;

	indexed_min_heap_queue_top dut (.*);

	heap_checker checker_inst (.*);

	// Watchdog: any accepted request or result beat resets the idle counter.
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with no traffic");
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it; start is left high and is
	// lowered only before a random gap or by the caller.
	task automatic send_request(input logic [1:0] rq, input logic [7:0] k,
			input logic [31:0] pr, input bit allow_gap);
		int gap;
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		key <= k;
		prio <= pr;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_sent++;
	endtask

	// Random priority that favors small ranges at both ends so ties and equal children appear.
	function automatic logic [31:0] pick_prio();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7);
			1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_key(bit narrow);
		return narrow ? 8'($urandom_range(0, 15)) : 8'($urandom);
	endfunction

	initial begin
		int r;
		bit narrow;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: empty pops and queries, field extremes, ties,
		// decrease-key and increase-key, and the unused request code.
		send_request(REQ_POP, 8'd0, 32'd0, 0);
		send_request(REQ_QUERY, 8'd255, 32'd0, 0);
		send_request(2'd3, 8'hAA, 32'h5555_5555, 0);
		send_request(REQ_UPSERT, 8'd0, 32'hFFFF_FFFF, 0);
		send_request(REQ_UPSERT, 8'd255, 32'd0, 0);
		send_request(REQ_UPSERT, 8'd7, 32'd5, 0);
		send_request(REQ_UPSERT, 8'd8, 32'd5, 0);
		send_request(REQ_UPSERT, 8'd9, 32'd5, 0);
		send_request(REQ_UPSERT, 8'd0, 32'd1, 0);
		send_request(REQ_UPSERT, 8'd255, 32'hFFFF_FFFE, 0);
		send_request(REQ_QUERY, 8'd255, 32'd0, 0);
		send_request(REQ_QUERY, 8'd100, 32'd0, 0);
		send_request(REQ_UPSERT, 8'h55, 32'hAAAA_AAAA, 0);
		send_request(REQ_UPSERT, 8'hAA, 32'h5555_5555, 0);
		send_request(2'd3, 8'd0, 32'd0, 0);
		repeat (8) send_request(REQ_POP, 8'd0, 32'd0, 0);
		send_request(REQ_QUERY, 8'd0, 32'd0, 0);

		// Pause until all results are in.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// Fill the heap completely so that the full-count case and the
		// deepest sifts are reached, then drain part of it.
		for (int k = 0; k < 256; k++) begin
			send_request(REQ_UPSERT, 8'(k), pick_prio(), 1);
			n_fill++;
		end
		send_request(REQ_UPSERT, 8'd3, 32'd0, 1);
		repeat (100) send_request(REQ_POP, 8'd0, 32'd0, 1);

		// Random mix; small key windows make updates and hits common.
		for (int i = 0; i < 1620; i++) begin
			narrow = ((i / 200) % 2) != 0;
			r = $urandom_range(0, 99);
			if (r < 50) send_request(REQ_UPSERT, pick_key(narrow), pick_prio(), i < 1400);
			else if (r < 75) send_request(REQ_POP, pick_key(narrow), $urandom, i < 1400);
			else if (r < 97) send_request(REQ_QUERY, pick_key(narrow), $urandom, i < 1400);
			else send_request(2'd3, pick_key(narrow), $urandom, i < 1400);
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d requests, including a full fill of %0d keys, ties,", n_sent, n_fill);
		$display("decrease/increase-key updates, empty pops and misses.");
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/imhq_pkg.sv
rtl/core/imhq_cell.sv
rtl/core/indexed_min_heap_queue_top.sv
tb/heap_checker.sv
tb/testbench.sv
